/* design/sbs_pkg.sv */
package sbs_pkg;

	localparam int CB       = 13;
	localparam int SCORE_W  = 14;
	localparam int KEEP_W   = 6;
	localparam int AREA_W   = 2 * CB;
	localparam int Q_DEPTH  = 4;

	localparam int MAX_CANDIDATES_DEF = 256;
	localparam int MAX_KEPT_DEF       = 48;

	localparam logic [KEEP_W-1:0]  KEEP_LIMIT_RST = 6'd48;
	localparam logic [SCORE_W-1:0] WEAK_SCORE     = 14'd4000;
	localparam int                 STRONG_MIN     = 10;
	localparam logic [CB-1:0]      ROW_TOL_MIN    = 13'd12;

	typedef struct packed {
		logic [CB-1:0]      box_x;
		logic [CB-1:0]      box_y;
		logic [CB-1:0]      box_width;
		logic [CB-1:0]      box_height;
		logic [SCORE_W-1:0] box_score;
		logic               is_strong;
		logic               last_box;
	} cand_t;

	typedef struct packed {
		logic [CB-1:0] out_x;
		logic [CB-1:0] out_y;
		logic [CB-1:0] out_width;
		logic [CB-1:0] out_height;
		logic          out_last;
		logic          overflowed;
	} kept_t;

	// one stored candidate, with area and weak flag worked out up front
	typedef struct packed {
		logic [CB-1:0]      x;
		logic [CB-1:0]      y;
		logic [CB-1:0]      w;
		logic [CB-1:0]      h;
		logic [SCORE_W-1:0] score;
		logic               low_score;
		logic [AREA_W-1:0]  area;
	} rec_t;

	typedef struct packed {
		rec_t rec;
		logic is_strong;
		logic last;
	} qitem_t;

	typedef struct packed {
		logic   push;
		qitem_t item;
	} qwr_t;

endpackage

/* design/sbs_front.sv */
module sbs_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  sbs_pkg::cand_t cand,
	input  logic           q_full,
	output sbs_pkg::qwr_t  q_wr
);
	import sbs_pkg::*;

	logic   v_s1;
	qitem_t item_s1;
	logic   take;

	assign full      = v_s1 && q_full;
	assign take      = push && !full;
	assign q_wr.push = v_s1 && !q_full;
	assign q_wr.item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (q_wr.push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.rec.x         <= cand.box_x;
			item_s1.rec.y         <= cand.box_y;
			item_s1.rec.w         <= cand.box_width;
			item_s1.rec.h         <= cand.box_height;
			item_s1.rec.score     <= cand.box_score;
			item_s1.rec.low_score <= cand.box_score < WEAK_SCORE;
			item_s1.rec.area      <= AREA_W'(cand.box_width) * AREA_W'(cand.box_height);
			item_s1.is_strong     <= cand.is_strong;
			item_s1.last          <= cand.last_box;
		end
	end

endmodule

/* design/sbs_fifo.sv */
module sbs_fifo #(
	parameter int DEPTH = sbs_pkg::Q_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  sbs_pkg::qwr_t   q_wr,
	output logic            q_full,
	output logic            q_valid,
	input  logic            q_pop,
	output sbs_pkg::qitem_t q_item
);
	import sbs_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	qitem_t        mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr, do_rd;

	assign q_full  = cnt_q == CW'(DEPTH);
	assign q_valid = cnt_q != '0;
	assign q_item  = mem_q[rp_q];
	assign do_wr   = q_wr.push && !q_full;
	assign do_rd   = q_pop && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= q_wr.item;
		end
	end

endmodule

/* design/sbs_back.sv */
module sbs_back #(
	parameter int MAX_CANDIDATES = sbs_pkg::MAX_CANDIDATES_DEF,
	parameter int MAX_KEPT       = sbs_pkg::MAX_KEPT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	output logic                       q_pop,
	input  sbs_pkg::qitem_t            q_item,
	input  logic                       cfg_we,
	input  logic [sbs_pkg::KEEP_W-1:0] cfg_wdata,
	output logic                       empty,
	input  logic                       pop,
	output sbs_pkg::kept_t             kept
);
	import sbs_pkg::*;

	localparam int IW  = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
	localparam int NW  = $clog2(MAX_CANDIDATES + 1);
	localparam int KW  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int KCW = $clog2(MAX_KEPT + 1);
	localparam int PW  = AREA_W + 7;
	localparam int DW  = AREA_W + 3;

	typedef enum logic [22:0] {
		S_LOAD = 23'd1 << 0,  S_SK_RD = 23'd1 << 1,  S_SK_LD = 23'd1 << 2,
		S_SJ   = 23'd1 << 3,  S_SJ2   = 23'd1 << 4,  S_SJ3   = 23'd1 << 5,
		S_PR   = 23'd1 << 6,  S_PB    = 23'd1 << 7,  S_PL    = 23'd1 << 8,
		S_KR   = 23'd1 << 9,  S_KB    = 23'd1 << 10, S_D1    = 23'd1 << 11,
		S_D2   = 23'd1 << 12, S_D3    = 23'd1 << 13, S_RI    = 23'd1 << 14,
		S_RIB  = 23'd1 << 15, S_RIL   = 23'd1 << 16, S_RJ    = 23'd1 << 17,
		S_RJ2  = 23'd1 << 18, S_RJ3   = 23'd1 << 19, S_ER    = 23'd1 << 20,
		S_EB   = 23'd1 << 21, S_EP    = 23'd1 << 22
	} st_t;

	st_t st_q;

	rec_t          box_mem [MAX_CANDIDATES];
	logic [IW-1:0] rank_mem [MAX_CANDIDATES];
	logic [IW-1:0] kept_mem [MAX_KEPT];

	rec_t          box_rd_q;
	logic [IW-1:0] rank_rd_q, kept_rd_q;
	logic [IW-1:0] box_ra, rank_ra, rank_wa, rank_wd, kept_wd;
	logic [KW-1:0] kept_ra, kept_wa;
	logic          box_we, rank_we, kept_we;

	logic [KEEP_W-1:0] keep_limit_q;
	logic [NW-1:0]     cnt_q, strong_q, n_q, i_q, j_q;
	logic [KCW-1:0]    kc_q, limit;
	logic              ovf_q, out_v_q;
	kept_t             out_q;

	logic [SCORE_W-1:0] key_score_q;
	logic [AREA_W-1:0]  key_area_q;
	logic [IW-1:0]      key_idx_q, prev_idx_q, cand_idx_q;
	rec_t               cand_q;

	logic [CB-1:0]     ow_q, oh_q;
	logic [CB:0]       adx_q, ady_q;
	logic [AREA_W:0]   sum_q;
	logic [AREA_W-1:0] small_q, inter_q;
	logic [DW-1:0]     d2_q;

	logic drop_weak, out_free, load_fits;
	logic ahead, reads_first, dup;

	assign empty     = !out_v_q;
	assign kept      = out_q;
	assign out_free  = !out_v_q || pop;
	assign drop_weak = 32'(strong_q) >= STRONG_MIN;
	assign load_fits = cnt_q < NW'(MAX_CANDIDATES);
	assign q_pop     = (st_q == S_LOAD) && q_valid;

	always_comb begin
		if (keep_limit_q == '0) begin
			limit = KCW'(1);
		end else if (32'(keep_limit_q) > MAX_KEPT) begin
			limit = KCW'(MAX_KEPT);
		end else begin
			limit = KCW'(keep_limit_q);
		end
	end

	// score order: scores that differ by at most one fall back to smaller area
	always_comb begin
		logic [SCORE_W-1:0] d;
		d = (key_score_q > box_rd_q.score) ? key_score_q - box_rd_q.score
		                                   : box_rd_q.score - key_score_q;
		if (d > SCORE_W'(1)) begin
			ahead = key_score_q > box_rd_q.score;
		end else begin
			ahead = key_area_q < box_rd_q.area;
		end
	end

	// reading order; cand_q holds the key box during that pass
	always_comb begin
		logic [CB-1:0] mh, half, tol, dy;
		mh   = (cand_q.h < box_rd_q.h) ? cand_q.h : box_rd_q.h;
		half = mh >> 1;
		tol  = (half > ROW_TOL_MIN) ? half : ROW_TOL_MIN;
		dy   = (cand_q.y > box_rd_q.y) ? cand_q.y - box_rd_q.y : box_rd_q.y - cand_q.y;
		if (dy <= tol) begin
			reads_first = cand_q.x < box_rd_q.x;
		end else begin
			reads_first = cand_q.y < box_rd_q.y;
		end
	end

	always_comb begin
		logic [AREA_W:0] uni;
		logic [PW-1:0]   lhs, r_iou, r_con;
		uni   = sum_q - (AREA_W + 1)'(inter_q);
		lhs   = PW'(inter_q) * PW'(100);
		r_iou = PW'(uni) * PW'(48);
		r_con = PW'(small_q) * PW'(90);
		dup   = ((inter_q != '0) && ((lhs >= r_iou) || (lhs >= r_con))) ||
		        (d2_q < DW'(100));
	end

	always_comb begin
		box_ra  = '0;
		rank_ra = '0;
		kept_ra = '0;
		box_we  = 1'b0;
		rank_we = 1'b0;
		rank_wa = '0;
		rank_wd = '0;
		kept_we = 1'b0;
		kept_wa = '0;
		kept_wd = '0;
		case (st_q)
			S_LOAD: box_we = q_valid && load_fits;
			S_SK_RD: box_ra = i_q[IW-1:0];
			S_SJ: begin
				if (j_q == '0) begin
					rank_we = 1'b1;
					rank_wd = key_idx_q;
				end else begin
					rank_ra = IW'(j_q - 1'b1);
				end
			end
			S_SJ2: box_ra = rank_rd_q;
			S_SJ3: begin
				rank_we = 1'b1;
				rank_wa = j_q[IW-1:0];
				rank_wd = ahead ? prev_idx_q : key_idx_q;
			end
			S_PR: rank_ra = i_q[IW-1:0];
			S_PB: box_ra = rank_rd_q;
			S_KR: begin
				if (32'(j_q) == 32'(kc_q)) begin
					kept_we = 1'b1;
					kept_wa = KW'(kc_q);
					kept_wd = cand_idx_q;
				end else begin
					kept_ra = KW'(j_q);
				end
			end
			S_KB: box_ra = kept_rd_q;
			S_RI: kept_ra = KW'(i_q);
			S_RIB: box_ra = kept_rd_q;
			S_RJ: begin
				if (j_q == '0) begin
					kept_we = 1'b1;
					kept_wd = key_idx_q;
				end else begin
					kept_ra = KW'(j_q - 1'b1);
				end
			end
			S_RJ2: box_ra = kept_rd_q;
			S_RJ3: begin
				kept_we = 1'b1;
				kept_wa = KW'(j_q);
				kept_wd = reads_first ? prev_idx_q : key_idx_q;
			end
			S_ER: kept_ra = KW'(i_q);
			S_EB, S_EP: begin
				kept_ra = KW'(i_q);
				box_ra  = kept_rd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (box_we) begin
			box_mem[cnt_q[IW-1:0]] <= q_item.rec;
		end
		box_rd_q <= box_mem[box_ra];
	end

	always_ff @(posedge clk) begin
		if (rank_we) begin
			rank_mem[rank_wa] <= rank_wd;
		end
		rank_rd_q <= rank_mem[rank_ra];
	end

	always_ff @(posedge clk) begin
		if (kept_we) begin
			kept_mem[kept_wa] <= kept_wd;
		end
		kept_rd_q <= kept_mem[kept_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_limit_q <= KEEP_LIMIT_RST;
		end else if (cfg_we) begin
			keep_limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_LOAD;
			cnt_q    <= '0;
			strong_q <= '0;
			ovf_q    <= 1'b0;
			n_q      <= '0;
			i_q      <= '0;
			j_q      <= '0;
			kc_q     <= '0;
			out_v_q  <= 1'b0;
		end else begin
			if (pop && out_v_q) begin
				out_v_q <= 1'b0;
			end
			case (st_q)
				S_LOAD: begin
					if (q_valid) begin
						if (load_fits) begin
							cnt_q    <= cnt_q + 1'b1;
							strong_q <= strong_q + NW'(q_item.is_strong);
						end else begin
							ovf_q <= 1'b1;
						end
						if (q_item.last) begin
							n_q  <= load_fits ? cnt_q + 1'b1 : cnt_q;
							i_q  <= '0;
							st_q <= S_SK_RD;
						end
					end
				end
				S_SK_RD: st_q <= S_SK_LD;
				S_SK_LD: begin
					j_q  <= i_q;
					st_q <= S_SJ;
				end
				S_SJ, S_SJ3: begin
					if (st_q == S_SJ3 && ahead) begin
						j_q  <= j_q - 1'b1;
						st_q <= S_SJ;
					end else if (st_q == S_SJ && j_q != '0) begin
						st_q <= S_SJ2;
					end else if (i_q + 1'b1 == n_q) begin
						i_q  <= '0;
						kc_q <= '0;
						st_q <= S_PR;
					end else begin
						i_q  <= i_q + 1'b1;
						st_q <= S_SK_RD;
					end
				end
				S_SJ2: st_q <= S_SJ3;
				S_PR: begin
					if (i_q == n_q || kc_q == limit) begin
						i_q  <= NW'(1);
						st_q <= S_RI;
					end else begin
						st_q <= S_PB;
					end
				end
				S_PB: st_q <= S_PL;
				S_PL: begin
					if (drop_weak && box_rd_q.low_score) begin
						i_q  <= i_q + 1'b1;
						st_q <= S_PR;
					end else begin
						j_q  <= '0;
						st_q <= S_KR;
					end
				end
				S_KR: begin
					if (32'(j_q) == 32'(kc_q)) begin
						kc_q <= kc_q + 1'b1;
						i_q  <= i_q + 1'b1;
						st_q <= S_PR;
					end else begin
						st_q <= S_KB;
					end
				end
				S_KB: st_q <= S_D1;
				S_D1: st_q <= S_D2;
				S_D2: st_q <= S_D3;
				S_D3: begin
					if (dup) begin
						i_q  <= i_q + 1'b1;
						st_q <= S_PR;
					end else begin
						j_q  <= j_q + 1'b1;
						st_q <= S_KR;
					end
				end
				S_RI: begin
					if (32'(i_q) < 32'(kc_q)) begin
						st_q <= S_RIB;
					end else begin
						i_q  <= '0;
						st_q <= S_ER;
					end
				end
				S_RIB: st_q <= S_RIL;
				S_RIL: begin
					j_q  <= i_q;
					st_q <= S_RJ;
				end
				S_RJ: begin
					if (j_q == '0) begin
						i_q  <= i_q + 1'b1;
						st_q <= S_RI;
					end else begin
						st_q <= S_RJ2;
					end
				end
				S_RJ2: st_q <= S_RJ3;
				S_RJ3: begin
					if (reads_first) begin
						j_q  <= j_q - 1'b1;
						st_q <= S_RJ;
					end else begin
						i_q  <= i_q + 1'b1;
						st_q <= S_RI;
					end
				end
				S_ER: begin
					if (32'(i_q) == 32'(kc_q)) begin
						cnt_q    <= '0;
						strong_q <= '0;
						ovf_q    <= 1'b0;
						kc_q     <= '0;
						st_q     <= S_LOAD;
					end else begin
						st_q <= S_EB;
					end
				end
				S_EB: st_q <= S_EP;
				S_EP: begin
					if (out_free) begin
						out_v_q <= 1'b1;
						i_q     <= i_q + 1'b1;
						st_q    <= S_ER;
					end
				end
				default: st_q <= S_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_SK_LD: begin
				key_score_q <= box_rd_q.score;
				key_area_q  <= box_rd_q.area;
				key_idx_q   <= i_q[IW-1:0];
			end
			S_SJ2: prev_idx_q <= rank_rd_q;
			S_PB: cand_idx_q <= rank_rd_q;
			S_PL: cand_q <= box_rd_q;
			S_D1: begin : overlap
				logic [CB-1:0] x1, y1;
				logic [CB:0]   ax2, bx2, ay2, by2, x2, y2, acx, bcx, acy, bcy;
				x1  = (cand_q.x > box_rd_q.x) ? cand_q.x : box_rd_q.x;
				y1  = (cand_q.y > box_rd_q.y) ? cand_q.y : box_rd_q.y;
				ax2 = {1'b0, cand_q.x} + {1'b0, cand_q.w};
				bx2 = {1'b0, box_rd_q.x} + {1'b0, box_rd_q.w};
				ay2 = {1'b0, cand_q.y} + {1'b0, cand_q.h};
				by2 = {1'b0, box_rd_q.y} + {1'b0, box_rd_q.h};
				x2  = (ax2 < bx2) ? ax2 : bx2;
				y2  = (ay2 < by2) ? ay2 : by2;
				ow_q <= (x2 > {1'b0, x1}) ? CB'(x2 - {1'b0, x1}) : '0;
				oh_q <= (y2 > {1'b0, y1}) ? CB'(y2 - {1'b0, y1}) : '0;
				acx = {1'b0, cand_q.x} + {1'b0, cand_q.w >> 1};
				bcx = {1'b0, box_rd_q.x} + {1'b0, box_rd_q.w >> 1};
				acy = {1'b0, cand_q.y} + {1'b0, cand_q.h >> 1};
				bcy = {1'b0, box_rd_q.y} + {1'b0, box_rd_q.h >> 1};
				adx_q   <= (acx > bcx) ? acx - bcx : bcx - acx;
				ady_q   <= (acy > bcy) ? acy - bcy : bcy - acy;
				sum_q   <= {1'b0, cand_q.area} + {1'b0, box_rd_q.area};
				small_q <= (cand_q.area < box_rd_q.area) ? cand_q.area : box_rd_q.area;
			end
			S_D2: begin
				inter_q <= AREA_W'(ow_q) * AREA_W'(oh_q);
				d2_q    <= DW'(adx_q) * DW'(adx_q) + DW'(ady_q) * DW'(ady_q);
			end
			S_RIB: key_idx_q <= kept_rd_q;
			S_RIL: cand_q <= box_rd_q;
			S_RJ2: prev_idx_q <= kept_rd_q;
			S_EP: begin
				if (out_free) begin
					out_q.out_x      <= box_rd_q.x;
					out_q.out_y      <= box_rd_q.y;
					out_q.out_width  <= box_rd_q.w;
					out_q.out_height <= box_rd_q.h;
					out_q.out_last   <= 32'(i_q) + 1 == 32'(kc_q);
					out_q.overflowed <= ovf_q;
				end
			end
			default: ;
		endcase
	end

endmodule

/* design/scored_box_suppression_core.sv */
// Load: one candidate beat per cycle while full is low; each beat is registered in
// the front stage, queued in the FIFO, then written to the box store. After the
// last beat: score sort (insertion, n^2/2 worst), suppression per candidate/kept
// pair, reading-order sort, then results out of the box store read port.
// Reset: asynchronous, clears counts and queues; keep_limit returns to 48.
// Box store needs no clearing pass; the next set loads as soon as reset drops.
module scored_box_suppression_core #(
	parameter int MAX_CANDIDATES = sbs_pkg::MAX_CANDIDATES_DEF,
	parameter int MAX_KEPT       = sbs_pkg::MAX_KEPT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  sbs_pkg::cand_t             cand,
	output logic                       empty,
	input  logic                       pop,
	output sbs_pkg::kept_t             kept,
	input  logic                       cfg_we,
	input  logic [sbs_pkg::KEEP_W-1:0] cfg_wdata
);
	import sbs_pkg::*;

	qwr_t   q_wr;
	qitem_t q_item;
	logic   q_full, q_valid, q_pop;

	sbs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.cand   (cand),
		.q_full (q_full),
		.q_wr   (q_wr)
	);

	sbs_fifo #(
		.DEPTH (Q_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_wr    (q_wr),
		.q_full  (q_full),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_item  (q_item)
	);

	sbs_back #(
		.MAX_CANDIDATES (MAX_CANDIDATES),
		.MAX_KEPT       (MAX_KEPT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_item    (q_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.empty     (empty),
		.pop       (pop),
		.kept      (kept)
	);

endmodule

/* test/scored_box_suppression_core_tb.sv */
`timescale 1ns / 100ps

module scored_box_suppression_core_tb;
	import sbs_pkg::*;

	localparam int STORE_DEPTH = MAX_CANDIDATES_DEF;
	localparam int KEPT_DEPTH  = MAX_KEPT_DEF;

	typedef struct {
		int unsigned x, y, w, h;
		int unsigned score;
	} nms_box_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	cand_t cand = '0;
	logic empty;
	logic pop = 1'b0;
	kept_t kept;
	logic cfg_we = 1'b0;
	logic [KEEP_W-1:0] cfg_wdata = '0;

	// predictor state
	nms_box_t set_boxes[STORE_DEPTH];
	int unsigned set_count;
	int unsigned strong_seen;
	bit set_dropped;
	int unsigned limit_reg = 32'(KEEP_LIMIT_RST);
	int unsigned last_set_size;

	kept_t kept_expected[$];
	int mismatches;
	int beats_sent, boxes_checked, sets_done, empty_sets;
	bit no_idle;

	scored_box_suppression_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.cand(cand),
		.empty(empty),
		.pop(pop),
		.kept(kept),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint unsigned box_area(nms_box_t b);
		return longint'(b.w) * longint'(b.h);
	endfunction

	function automatic bit ranks_higher(nms_box_t a, nms_box_t b);
		int unsigned sa, sb, d;
		sa = a.score;
		sb = b.score;
		d = sa > sb ? sa - sb : sb - sa;
		if (d > 1) begin
			return sa > sb;
		end
		return box_area(a) < box_area(b);
	endfunction

	function automatic bit overlaps_kept(nms_box_t c, nms_box_t k);
		int unsigned x1, y1, x2, y2;
		longint unsigned inter, ac, ak, lo, uni;
		longint dx, dy;
		x1 = c.x > k.x ? c.x : k.x;
		y1 = c.y > k.y ? c.y : k.y;
		x2 = (c.x + c.w) < (k.x + k.w) ? c.x + c.w : k.x + k.w;
		y2 = (c.y + c.h) < (k.y + k.h) ? c.y + c.h : k.y + k.h;
		inter = (x2 <= x1 || y2 <= y1) ? 0 : longint'(x2 - x1) * longint'(y2 - y1);
		ac = box_area(c);
		ak = box_area(k);
		lo = ac < ak ? ac : ak;
		if (inter > 0) begin
			uni = ac + ak - inter;
			if (uni > 0 && inter * 100 >= uni * 48)
				return 1'b1;
			if (lo > 0 && inter * 100 >= lo * 90)
				return 1'b1;
		end
		dx = longint'(c.x + c.w / 2) - longint'(k.x + k.w / 2);
		dy = longint'(c.y + c.h / 2) - longint'(k.y + k.h / 2);
		return dx * dx + dy * dy < 100;
	endfunction

	function automatic bit reads_first(nms_box_t a, nms_box_t b);
		int unsigned mh, tol, dy;
		mh = a.h < b.h ? a.h : b.h;
		tol = mh / 2 > ROW_TOL_MIN ? mh / 2 : ROW_TOL_MIN;
		dy = a.y > b.y ? a.y - b.y : b.y - a.y;
		if (dy <= tol)
			return a.x < b.x;
		return a.y < b.y;
	endfunction

	// greedy suppression over the stored set, results go to kept_expected
	task automatic run_suppression();
		int order[STORE_DEPTH];
		int picks[KEPT_DEPTH];
		int n_pick, lim, j, key;
		bit skip_weak, dup;
		kept_t r;
		for (int i = 0; i < set_count; i++) begin
			j = i;
			while (j > 0 && ranks_higher(set_boxes[i], set_boxes[order[j-1]])) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = i;
		end
		lim = limit_reg < 1 ? 1 : (limit_reg > KEPT_DEPTH ? KEPT_DEPTH : limit_reg);
		skip_weak = strong_seen >= STRONG_MIN;
		n_pick = 0;
		for (int i = 0; i < set_count && n_pick < lim; i++) begin
			if (skip_weak && set_boxes[order[i]].score < WEAK_SCORE)
				continue;
			dup = 1'b0;
			for (int k = 0; k < n_pick && !dup; k++)
				dup = overlaps_kept(set_boxes[order[i]], set_boxes[picks[k]]);
			if (!dup) begin
				picks[n_pick] = order[i];
				n_pick++;
			end
		end
		for (int i = 1; i < n_pick; i++) begin
			key = picks[i];
			j = i;
			while (j > 0 && reads_first(set_boxes[key], set_boxes[picks[j-1]])) begin
				picks[j] = picks[j-1];
				j--;
			end
			picks[j] = key;
		end
		for (int i = 0; i < n_pick; i++) begin
			r.out_x = CB'(set_boxes[picks[i]].x);
			r.out_y = CB'(set_boxes[picks[i]].y);
			r.out_width = CB'(set_boxes[picks[i]].w);
			r.out_height = CB'(set_boxes[picks[i]].h);
			r.out_last = (i + 1 == n_pick);
			r.overflowed = set_dropped;
			kept_expected = {kept_expected, r};
		end
		if (n_pick == 0)
			empty_sets++;
		sets_done++;
		last_set_size = set_count;
		set_count = 0;
		strong_seen = 0;
		set_dropped = 1'b0;
	endtask

	task automatic absorb_box(cand_t c);
		if (set_count < STORE_DEPTH) begin
			set_boxes[set_count] = '{c.box_x, c.box_y, c.box_width, c.box_height, c.box_score};
			if (c.is_strong)
				strong_seen++;
			set_count++;
		end else begin
			set_dropped = 1'b1;
		end
		if (c.last_box)
			run_suppression();
	endtask

	// push one beat; push stays high afterwards so back-to-back beats need no toggle
	task automatic send_box(cand_t c);
		while (!no_idle && $urandom_range(99) < 35) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		cand <= c;
		@(posedge clk);
		while (full)
			@(posedge clk);
		beats_sent++;
		absorb_box(c);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (kept_expected.size() > 0)
			@(posedge clk);
		// a set that keeps nothing leaves no result to wait for
		repeat (2 * last_set_size * last_set_size + 300 * last_set_size + 2000)
			@(posedge clk);
	endtask

	task automatic write_limit(int unsigned v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= KEEP_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_reg = v;
	endtask

	function automatic cand_t make_box(int unsigned x, int unsigned y, int unsigned w,
			int unsigned h, int unsigned s, bit ctl, bit last);
		cand_t c;
		c.box_x = CB'(x);
		c.box_y = CB'(y);
		c.box_width = CB'(w);
		c.box_height = CB'(h);
		c.box_score = SCORE_W'(s);
		c.is_strong = ctl;
		c.last_box = last;
		return c;
	endfunction

	function automatic cand_t random_box(int unsigned cx, int unsigned cy, bit wide, bit last);
		cand_t c;
		if (wide) begin
			c.box_x = CB'($urandom);
			c.box_y = CB'($urandom);
			c.box_width = CB'($urandom);
			c.box_height = CB'($urandom);
			c.box_score = SCORE_W'($urandom);
			c.is_strong = 1'($urandom);
		end else begin
			c.box_x = CB'(cx + $urandom_range(40));
			c.box_y = CB'(cy + $urandom_range(40));
			c.box_width = CB'($urandom_range(60, 1));
			c.box_height = CB'($urandom_range(60, 1));
			c.box_score = $urandom_range(9) < 3 ? SCORE_W'(4000 + $urandom_range(2) - 1)
				: SCORE_W'($urandom_range(8000));
			c.is_strong = 1'($urandom_range(1));
		end
		c.last_box = last;
		return c;
	endfunction

	task automatic send_random_set(int unsigned n);
		int unsigned cx, cy;
		cx = $urandom_range(8000);
		cy = $urandom_range(8000);
		for (int i = 0; i < n; i++)
			send_box(random_box(cx, cy, $urandom_range(9) == 0, i == n - 1));
	endtask

	task automatic test_directed();
		// extremes, degenerate sizes, score ties that differ by at most one
		send_box(make_box(8191, 8191, 8191, 8191, 16383, 1, 0));
		send_box(make_box(0, 0, 0, 5, 0, 0, 0));
		send_box(make_box(2, 3, 7, 0, 0, 0, 0));
		send_box(make_box(100, 100, 50, 50, 500, 0, 0));
		send_box(make_box(101, 100, 40, 50, 501, 0, 0));
		send_box(make_box(300, 100, 30, 30, 500, 1, 0));
		send_box(make_box(310, 110, 10, 10, 499, 0, 0));
		send_box(make_box(200, 105, 20, 20, 500, 0, 1));
		// ten strong boxes: weak scores are skipped
		for (int i = 0; i < 10; i++)
			send_box(make_box(i * 100, 500, 30, 30, 4000 + i, 1, 0));
		send_box(make_box(2000, 500, 30, 30, 3999, 0, 0));
		send_box(make_box(2200, 500, 30, 30, 16383, 0, 1));
		// all weak with ten strong: nothing kept
		for (int i = 0; i < 10; i++)
			send_box(make_box(i * 50, 0, 9, 9, 10, 1, i == 9));
		// a single box set
		send_box(make_box(7, 7, 1, 1, 1, 0, 1));
	endtask

	task automatic test_keep_limit();
		int unsigned lims[4] = '{1, 0, 5, 49};
		foreach (lims[i]) begin
			write_limit(lims[i]);
			for (int k = 0; k < 12; k++)
				send_box(make_box(k * 200, 200 + k, 20, 20,
					$urandom_range(16383), 0, k == 11));
		end
	endtask

	task automatic test_overflow();
		// a limit above the kept capacity saturates
		write_limit(63);
		// the dropped last beat still starts selection
		for (int i = 0; i < STORE_DEPTH + 2; i++)
			send_box(make_box((i % 16) * 400, (i / 16) * 400, 25, 25,
				$urandom_range(16383), i % 3 == 0, i == STORE_DEPTH + 1));
		drain();
	endtask

	task automatic test_random();
		int unsigned sent;
		sent = 0;
		no_idle = 1'b1;
		while (sent < 130) begin
			automatic int unsigned n = $urandom_range(20, 1);
			if (sent > 60)
				no_idle = 1'b0;
			if ($urandom_range(15) == 0) begin
				write_limit($urandom_range(63));
			end
			send_random_set(n);
			sent += n;
		end
	endtask

	// result side: random pop, compare each accepted beat
	always @(posedge clk) begin
		if (pop && !empty) begin
			if (kept_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %p", kept);
			end else begin
				automatic kept_t e = kept_expected.pop_front();
				boxes_checked++;
				if (kept !== e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %p got %p", e, kept);
				end
			end
		end
		pop <= no_idle || $urandom_range(99) >= 35;
	end

	initial begin
		#40000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_keep_limit();
		test_overflow();
		test_random();
		drain();
		$display("%0d boxes sent in %0d sets (%0d with nothing kept), %0d kept boxes checked",
			beats_sent, sets_done, empty_sets, boxes_checked);
		$display("covered extremes, score ties, weak skipping, keep limits and store overflow");
		if (mismatches == 0 && kept_expected.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
